### sv/b64e_pkg.sv
// ----------------------------------------------------------------------------
// b64e_pkg
// Shared types, slot codes and character constants of the Base64 encoder.
// ----------------------------------------------------------------------------
package b64e_pkg;

    localparam int SLOT_BITS = 4;
    localparam int NUM_SLOTS = 9;

    typedef logic [SLOT_BITS-1:0] t_slot;
    typedef logic [NUM_SLOTS-1:0] t_mask;

    localparam t_slot SLOT_SYM0 = 4'd0;
    localparam t_slot SLOT_SYM1 = 4'd1;
    localparam t_slot SLOT_CR0  = 4'd2;
    localparam t_slot SLOT_LF0  = 4'd3;
    localparam t_slot SLOT_EQ0  = 4'd4;
    localparam t_slot SLOT_EQ1  = 4'd5;
    localparam t_slot SLOT_CR1  = 4'd6;
    localparam t_slot SLOT_LF1  = 4'd7;
    localparam t_slot SLOT_NUL  = 4'd8;

    localparam logic [1:0] REG_LINE_BREAK = 2'd0;
    localparam logic [1:0] REG_PAD        = 2'd1;
    localparam logic [1:0] REG_NUL_END    = 2'd2;

    localparam logic [7:0] CHAR_EQ  = 8'h3D;
    localparam logic [7:0] CHAR_CR  = 8'h0D;
    localparam logic [7:0] CHAR_LF  = 8'h0A;
    localparam logic [7:0] CHAR_NUL = 8'h00;

    typedef struct packed {
        logic [5:0] sym0;
        logic [5:0] sym1;
        t_mask      mask;
    } t_job;

    function automatic logic [7:0] b64_char(input logic [5:0] idx);
        logic [7:0] c;
        if (idx < 6'd26) begin
            c = 8'h41 + {2'b00, idx};
        end else if (idx < 6'd52) begin
            c = 8'h61 + {2'b00, idx} - 8'd26;
        end else if (idx < 6'd62) begin
            c = 8'h30 + {2'b00, idx} - 8'd52;
        end else if (idx == 6'd62) begin
            c = 8'h2B;
        end else begin
            c = 8'h2F;
        end
        return c;
    endfunction

endpackage

### sv/b64e_front.sv
// ----------------------------------------------------------------------------
// b64e_front
// Accepts message bytes, tracks group phase, held bits and line count, and
// turns each transaction into a job of character slots for the back end.
// ----------------------------------------------------------------------------
module b64e_front #(
    parameter int LINE_CHARS = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    input  logic [1:0]        i_cfg_index,
    input  logic [0:0]        i_cfg_data,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [7:0]        i_data_byte,
    input  logic              i_is_last,
    input  logic              i_no_data,
    input  logic              i_q_full,
    output logic              o_push,
    output b64e_pkg::t_job    o_job
);

    localparam logic [6:0] LineLimit = 7'(LINE_CHARS);

    logic       r_lbe, r_pad, r_nul;
    logic [1:0] r_phase, n_phase;
    logic [3:0] r_held, n_held;
    logic [6:0] r_lc, n_lc;

    logic       has_data, accept, mid_crlf, flush, eq1, eq2, end_crlf;
    logic [1:0] ph_d, ndsym, nend;
    logic [3:0] held_d;
    logic [5:0] dsym0, dsym1, fsym;
    logic [6:0] lc1, lc2, lc3;
    b64e_pkg::t_job job;

    function automatic logic [6:0] sat_add(input logic [6:0] a, input logic [1:0] b);
        logic [7:0] s;
        s = {1'b0, a} + {6'b0, b};
        return s[7] ? 7'h7F : s[6:0];
    endfunction

    always_comb begin
        has_data = !i_no_data;
        dsym0    = '0;
        dsym1    = '0;
        ndsym    = 2'd0;
        ph_d     = r_phase;
        held_d   = r_held;
        if (has_data) begin
            case (r_phase)
                2'd0: begin
                    dsym0  = i_data_byte[7:2];
                    held_d = {2'b00, i_data_byte[1:0]};
                    ph_d   = 2'd1;
                    ndsym  = 2'd1;
                end
                2'd1: begin
                    dsym0  = {r_held[1:0], i_data_byte[7:4]};
                    held_d = i_data_byte[3:0];
                    ph_d   = 2'd2;
                    ndsym  = 2'd1;
                end
                default: begin
                    dsym0  = {r_held, i_data_byte[7:6]};
                    dsym1  = i_data_byte[5:0];
                    held_d = 4'd0;
                    ph_d   = 2'd0;
                    ndsym  = 2'd2;
                end
            endcase
        end

        lc1      = r_lbe ? sat_add(r_lc, ndsym) : r_lc;
        mid_crlf = r_lbe && (ndsym == 2'd2) && (lc1 >= LineLimit);
        lc2      = mid_crlf ? 7'd0 : lc1;

        flush    = i_is_last && (ph_d != 2'd0);
        fsym     = (ph_d == 2'd1) ? {held_d[1:0], 4'b0000} : {held_d, 2'b00};
        eq1      = i_is_last && r_pad;
        eq2      = eq1 && (ph_d == 2'd1);
        nend     = {1'b0, flush} + {1'b0, eq1} + {1'b0, eq2};
        lc3      = r_lbe ? sat_add(lc2, nend) : lc2;
        end_crlf = i_is_last && r_lbe && (lc3 != 7'd0);

        job.sym0 = has_data ? dsym0 : fsym;
        job.sym1 = (ndsym == 2'd2) ? dsym1 : fsym;
        job.mask = '0;
        job.mask[b64e_pkg::SLOT_SYM0] = has_data || flush;
        job.mask[b64e_pkg::SLOT_SYM1] = (ndsym == 2'd2) || (has_data && flush);
        job.mask[b64e_pkg::SLOT_CR0]  = mid_crlf;
        job.mask[b64e_pkg::SLOT_LF0]  = mid_crlf;
        job.mask[b64e_pkg::SLOT_EQ0]  = eq1;
        job.mask[b64e_pkg::SLOT_EQ1]  = eq2;
        job.mask[b64e_pkg::SLOT_CR1]  = end_crlf;
        job.mask[b64e_pkg::SLOT_LF1]  = end_crlf;
        job.mask[b64e_pkg::SLOT_NUL]  = i_is_last && r_nul;

        n_phase = i_is_last ? 2'd0 : ph_d;
        n_held  = i_is_last ? 4'd0 : held_d;
        n_lc    = i_is_last ? 7'd0 : lc2;
    end

    assign o_ready = !i_q_full;
    assign accept  = i_valid && o_ready;
    assign o_push  = accept && (job.mask != '0);
    assign o_job   = job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lbe   <= 1'b0;
            r_pad   <= 1'b0;
            r_nul   <= 1'b0;
            r_phase <= 2'd0;
            r_held  <= 4'd0;
            r_lc    <= 7'd0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    b64e_pkg::REG_LINE_BREAK: r_lbe <= i_cfg_data[0];
                    b64e_pkg::REG_PAD:        r_pad <= i_cfg_data[0];
                    b64e_pkg::REG_NUL_END:    r_nul <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (accept) begin
                r_phase <= n_phase;
                r_held  <= n_held;
                r_lc    <= n_lc;
            end
        end
    end

endmodule

### sv/b64e_queue.sv
// ----------------------------------------------------------------------------
// b64e_queue
// Two-entry job queue between the front end and the character sequencer.
// ----------------------------------------------------------------------------
module b64e_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  b64e_pkg::t_job i_job,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_nonempty,
    output b64e_pkg::t_job o_head
);

    b64e_pkg::t_job r_mem [2];
    logic           r_wr, r_rd;
    logic [1:0]     r_cnt;

    assign o_full     = (r_cnt == 2'd2);
    assign o_nonempty = (r_cnt != 2'd0);
    assign o_head     = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= !r_wr;
            end
            if (i_pop) begin
                r_rd <= !r_rd;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

endmodule

### sv/b64e_back.sv
// ----------------------------------------------------------------------------
// b64e_back
// Character sequencer: walks the enabled slots of each job, one character
// per cycle while the output is not stalled, into a registered output stage.
// ----------------------------------------------------------------------------
module b64e_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_nonempty,
    input  b64e_pkg::t_job i_q_head,
    output logic           o_pop,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [7:0]     o_out_char,
    output logic           o_last_out
);

    logic                r_busy, r_ov, r_last;
    logic [7:0]          r_char;
    b64e_pkg::t_job      r_job, n_job;

    logic                cur_valid, fire;
    b64e_pkg::t_job      cur_job;
    b64e_pkg::t_mask     low_bit, rem;
    b64e_pkg::t_slot     sel;
    logic [7:0]          ch;

    always_comb begin
        cur_valid = r_busy || i_q_nonempty;
        cur_job   = r_busy ? r_job : i_q_head;
        sel       = '0;
        for (int i = b64e_pkg::NUM_SLOTS - 1; i >= 0; i--) begin
            if (cur_job.mask[i]) begin
                sel = b64e_pkg::t_slot'(i);
            end
        end
        low_bit = b64e_pkg::t_mask'(1) << sel;
        rem     = cur_job.mask & ~low_bit;
        n_job      = cur_job;
        n_job.mask = rem;
        case (sel)
            b64e_pkg::SLOT_SYM0: ch = b64e_pkg::b64_char(cur_job.sym0);
            b64e_pkg::SLOT_SYM1: ch = b64e_pkg::b64_char(cur_job.sym1);
            b64e_pkg::SLOT_CR0:  ch = b64e_pkg::CHAR_CR;
            b64e_pkg::SLOT_LF0:  ch = b64e_pkg::CHAR_LF;
            b64e_pkg::SLOT_EQ0:  ch = b64e_pkg::CHAR_EQ;
            b64e_pkg::SLOT_EQ1:  ch = b64e_pkg::CHAR_EQ;
            b64e_pkg::SLOT_CR1:  ch = b64e_pkg::CHAR_CR;
            b64e_pkg::SLOT_LF1:  ch = b64e_pkg::CHAR_LF;
            b64e_pkg::SLOT_NUL:  ch = b64e_pkg::CHAR_NUL;
            default:             ch = b64e_pkg::CHAR_NUL;
        endcase
    end

    assign fire       = cur_valid && (!r_ov || i_ready);
    assign o_pop      = fire && !r_busy;
    assign o_valid    = r_ov;
    assign o_out_char = r_char;
    assign o_last_out = r_last;

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_char <= ch;
            r_last <= (rem == '0);
            r_job  <= n_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_ov   <= 1'b0;
        end else begin
            if (fire) begin
                r_busy <= (rem != '0);
                r_ov   <= 1'b1;
            end else if (i_ready) begin
                r_ov   <= 1'b0;
            end
        end
    end

endmodule

### sv/base64_stream_encoder.sv
// ----------------------------------------------------------------------------
// base64_stream_encoder
// Streaming Base64 encoder with optional CR LF line breaks, '=' terminator
// and padding, and a closing NUL.
//
//   channel   handshake                  payload
//   input     i_valid / o_ready          i_data_byte, i_is_last, i_no_data
//   output    o_valid / i_ready          o_out_char, o_last_out
//   config    i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// A byte is taken every cycle while the two-entry job queue has room; each
// transaction yields 0 to 8 characters. The output port moves one character
// per cycle while i_ready is high, so it sets the rate. Reset is synchronous
// and clears all control and encoder state. An output stall backs up through
// the queue to o_ready.
// ----------------------------------------------------------------------------
module base64_stream_encoder #(
    parameter int LINE_CHARS = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  logic [0:0] i_cfg_data,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_data_byte,
    input  logic       i_is_last,
    input  logic       i_no_data,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_out_char,
    output logic       o_last_out
);

    logic           push, pop, q_full, q_nonempty;
    b64e_pkg::t_job job, head;

    assign o_cfg_ready = 1'b1;

    b64e_front #(
        .LINE_CHARS (LINE_CHARS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_data_byte (i_data_byte),
        .i_is_last   (i_is_last),
        .i_no_data   (i_no_data),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_job       (job)
    );

    b64e_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_job      (job),
        .i_pop      (pop),
        .o_full     (q_full),
        .o_nonempty (q_nonempty),
        .o_head     (head)
    );

    b64e_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_nonempty (q_nonempty),
        .i_q_head     (head),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_out_char   (o_out_char),
        .o_last_out   (o_last_out)
    );

endmodule

### sv/b64e_checker.sv
// ----------------------------------------------------------------------------
// b64e_checker
// Port-level checks of the Base64 encoder, bound to the top level.
// ----------------------------------------------------------------------------
module b64e_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_ready,
    input logic [7:0] o_out_char,
    input logic       o_last_out
);

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_out_char) && $stable(o_last_out))
        else $error("stalled output transaction changed");

    a_cr_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_out_char == b64e_pkg::CHAR_CR) |-> !o_last_out)
        else $error("CR closed a transaction");

    a_nul_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_out_char == b64e_pkg::CHAR_NUL) |-> o_last_out)
        else $error("NUL not marked last");

endmodule

bind base64_stream_encoder b64e_checker u_b64e_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_valid    (o_valid),
    .i_ready    (i_ready),
    .o_out_char (o_out_char),
    .o_last_out (o_last_out)
);
